// ===== sv/nlra_pkg.sv =====
// nlra_pkg: shared types and constants of the nv21 remap address generator
// no dependencies; imported by every module of the block

package nlra_pkg;

  localparam int ADDR_W    = 24;
  localparam int COORD_W   = 12;
  localparam int SIZE_CFG_W = 13;
  localparam int OFF_W     = 12;
  localparam int SIZE_W    = 14;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd5;

  typedef struct packed {
    logic [SIZE_CFG_W-1:0] region_rows;
    logic [SIZE_CFG_W-1:0] region_cols;
    logic [OFF_W-1:0]      offset_x;
    logic [OFF_W-1:0]      offset_y;
    logic [SIZE_CFG_W-1:0] dst_width;
    logic [SIZE_CFG_W-1:0] src_width;
  } cfg_t;

  typedef struct packed {
    logic chroma;
    logic done;
  } entry_flags_t;

  typedef struct packed {
    logic [ADDR_W-1:0] luma_rd;
    logic [ADDR_W-1:0] luma_wr;
    logic [ADDR_W-1:0] chroma_rd;
    logic [ADDR_W-1:0] chroma_wr;
  } cmd_addr_t;

endpackage

// ===== sv/nlra_position.sv =====
// nlra_position: region row/column counters and the input register stage
// depends on nlra_pkg

module nlra_position import nlra_pkg::*; #(
  parameter int MAX_DIM = 4096,
  localparam int CW = $clog2(MAX_DIM),
  localparam int PW = ((CW > COORD_W) ? CW : COORD_W) + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               accept,
  input  logic [COORD_W-1:0] map_src_col,
  input  logic [COORD_W-1:0] map_src_row,
  input  logic               advance,
  output logic               a_valid,
  output logic [COORD_W-1:0] a_cs,
  output logic [COORD_W-1:0] a_rs,
  output logic [PW-1:0]      a_rd,
  output logic [PW-1:0]      a_cd,
  output entry_flags_t       a_flags
);

  logic [CW-1:0]     row_count;
  logic [CW-1:0]     col_count;
  logic [SIZE_W-1:0] rows;
  logic [SIZE_W-1:0] cols;
  logic              last_col;
  logic              last_row;
  logic [PW-1:0]     rd;
  logic [PW-1:0]     cd;

  function automatic logic [SIZE_W-1:0] clamp_dim(input logic [SIZE_CFG_W-1:0] v);
    logic [SIZE_W-1:0] w;
    w = SIZE_W'(v);
    if (w == '0) begin
      return SIZE_W'(1);
    end else if (w > SIZE_W'(MAX_DIM)) begin
      return SIZE_W'(MAX_DIM);
    end
    return w;
  endfunction

  always_comb begin
    rows     = clamp_dim(cfg.region_rows);
    cols     = clamp_dim(cfg.region_cols);
    last_col = (SIZE_W'(col_count) + SIZE_W'(1)) >= cols;
    last_row = (SIZE_W'(row_count) + SIZE_W'(1)) >= rows;
    rd       = PW'(row_count) + PW'(cfg.offset_y);
    cd       = PW'(col_count) + PW'(cfg.offset_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      a_valid   <= 1'b0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
        if (last_col) begin
          col_count <= '0;
          row_count <= last_row ? '0 : row_count + CW'(1);
        end else begin
          col_count <= col_count + CW'(1);
        end
      end else if (advance) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_cs           <= map_src_col;
      a_rs           <= map_src_row;
      a_rd           <= rd;
      a_cd           <= cd;
      a_flags.chroma <= rd[0] & cd[0];
      a_flags.done   <= last_col & last_row;
    end
  end

endmodule

// ===== sv/nlra_addr_calc.sv =====
// nlra_addr_calc: luma and chroma address products, one register stage
// depends on nlra_pkg

module nlra_addr_calc import nlra_pkg::*; #(
  parameter int MAX_DIM = 4096,
  localparam int CW = $clog2(MAX_DIM),
  localparam int PW = ((CW > COORD_W) ? CW : COORD_W) + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               load,
  input  logic [COORD_W-1:0] a_cs,
  input  logic [COORD_W-1:0] a_rs,
  input  logic [PW-1:0]      a_rd,
  input  logic [PW-1:0]      a_cd,
  input  entry_flags_t       a_flags,
  input  logic               advance,
  output logic               b_valid,
  output cmd_addr_t          b_addr,
  output entry_flags_t       b_flags
);

  logic [ADDR_W-1:0] sw;
  logic [ADDR_W-1:0] dw;
  logic [ADDR_W-1:0] ce;
  cmd_addr_t         addr;

  always_comb begin
    sw             = ADDR_W'(cfg.src_width);
    dw             = ADDR_W'(cfg.dst_width);
    ce             = ADDR_W'({a_cs[COORD_W-1:1], 1'b0});
    addr.luma_rd   = ADDR_W'(a_rs) * sw + ADDR_W'(a_cs);
    addr.luma_wr   = ADDR_W'(a_rd) * dw + ADDR_W'(a_cd);
    addr.chroma_rd = ADDR_W'(a_rs[COORD_W-1:1]) * sw + ce;
    addr.chroma_wr = ADDR_W'(a_rd[PW-1:1]) * dw + ADDR_W'(a_cd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (load) begin
      b_valid <= 1'b1;
    end else if (advance) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b_addr  <= addr;
      b_flags <= a_flags;
    end
  end

endmodule

// ===== sv/nlra_cmd_seq.sv =====
// nlra_cmd_seq: holds one entry and issues its one or three copy commands
// depends on nlra_pkg

module nlra_cmd_seq import nlra_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  cmd_addr_t    b_addr,
  input  entry_flags_t b_flags,
  output logic         slot_free,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [47:0]  m_tdata,
  output logic [1:0]   m_tuser,
  output logic         m_tlast
);

  localparam logic [1:0] CMD_LUMA      = 2'd0;
  localparam logic [1:0] CMD_CHROMA_LO = 2'd1;
  localparam logic [1:0] CMD_CHROMA_HI = 2'd2;

  logic              slot_valid;
  logic [1:0]        idx;
  cmd_addr_t         addr;
  entry_flags_t      flags;
  logic              last_cmd;
  logic [ADDR_W-1:0] read_addr;
  logic [ADDR_W-1:0] write_addr;

  always_comb begin
    last_cmd  = ((idx == CMD_LUMA) && !flags.chroma) || (idx == CMD_CHROMA_HI);
    slot_free = !slot_valid || (m_tready && last_cmd);
    case (idx)
      CMD_LUMA: begin
        read_addr  = addr.luma_rd;
        write_addr = addr.luma_wr;
      end
      CMD_CHROMA_LO: begin
        read_addr  = addr.chroma_rd;
        write_addr = addr.chroma_wr - ADDR_W'(1);
      end
      CMD_CHROMA_HI: begin
        read_addr  = addr.chroma_rd + ADDR_W'(1);
        write_addr = addr.chroma_wr;
      end
      default: begin
        read_addr  = addr.luma_rd;
        write_addr = addr.luma_wr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      idx        <= CMD_LUMA;
    end else if (slot_free) begin
      slot_valid <= load;
      idx        <= CMD_LUMA;
    end else if (m_tready) begin
      case (idx)
        CMD_LUMA:      idx <= CMD_CHROMA_LO;
        CMD_CHROMA_LO: idx <= CMD_CHROMA_HI;
        default:       idx <= CMD_LUMA;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load && slot_free) begin
      addr  <= b_addr;
      flags <= b_flags;
    end
  end

  assign m_tvalid = slot_valid;
  assign m_tdata  = {write_addr, read_addr};
  assign m_tuser  = {last_cmd, (idx != CMD_LUMA)};
  assign m_tlast  = last_cmd && flags.done;

endmodule

// ===== sv/nv21_lut_remap_address_gen.sv =====
// nv21_lut_remap_address_gen: top level of the nv21 remap address generator
// depends on nlra_pkg, nlra_position, nlra_addr_calc, nlra_cmd_seq

// Takes one remap entry (source column, row) per destination pixel in raster
// order over the configured region and issues copy commands: one luma copy
// per entry, plus two interleaved chroma byte copies when the destination row
// and column are both odd. An entry passes an input register, an address
// register (one multiply-add per address) and a command slot, in that order.
// The command slot issues one command per cycle while m_tready is high, and
// input is taken every cycle while the output keeps pace. Configuration is
// taken at any time and must only change while the block is idle.

module nv21_lut_remap_address_gen import nlra_pkg::*; #(
  parameter int MAX_DIM = 4096,
  localparam int CW = $clog2(MAX_DIM),
  localparam int PW = ((CW > COORD_W) ? CW : COORD_W) + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,   // map_src_col[11:0], map_src_row[23:12]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [47:0]           m_tdata,   // read_addr[23:0], write_addr[47:24]
  output logic [1:0]            m_tuser,   // plane[0], last_of_entry[1]
  output logic                  m_tlast    // region_done
);

  cfg_t               cfg;
  logic               accept;
  logic               a_valid;
  logic [COORD_W-1:0] a_cs;
  logic [COORD_W-1:0] a_rs;
  logic [PW-1:0]      a_rd;
  logic [PW-1:0]      a_cd;
  entry_flags_t       a_flags;
  logic               a_adv;
  logic               b_valid;
  cmd_addr_t          b_addr;
  entry_flags_t       b_flags;
  logic               b_adv;
  logic               b_take;
  logic               slot_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.region_rows <= SIZE_CFG_W'(1);
      cfg.region_cols <= SIZE_CFG_W'(1);
      cfg.offset_x    <= '0;
      cfg.offset_y    <= '0;
      cfg.dst_width   <= SIZE_CFG_W'(1280);
      cfg.src_width   <= SIZE_CFG_W'(1280);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_REGION_ROWS: cfg.region_rows <= cfg_data;
        REG_REGION_COLS: cfg.region_cols <= cfg_data;
        REG_OFFSET_X:    cfg.offset_x    <= cfg_data[OFF_W-1:0];
        REG_OFFSET_Y:    cfg.offset_y    <= cfg_data[OFF_W-1:0];
        REG_DST_WIDTH:   cfg.dst_width   <= cfg_data;
        REG_SRC_WIDTH:   cfg.src_width   <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage handoff
  always_comb begin
    b_adv    = b_valid && slot_free;
    b_take   = !b_valid || slot_free;
    a_adv    = a_valid && b_take;
    s_tready = !a_valid || b_take;
    accept   = s_tvalid && s_tready;
  end

  nlra_position #(.MAX_DIM(MAX_DIM)) u_position (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .map_src_col (s_tdata[11:0]),
    .map_src_row (s_tdata[23:12]),
    .advance     (a_adv),
    .a_valid     (a_valid),
    .a_cs        (a_cs),
    .a_rs        (a_rs),
    .a_rd        (a_rd),
    .a_cd        (a_cd),
    .a_flags     (a_flags)
  );

  nlra_addr_calc #(.MAX_DIM(MAX_DIM)) u_addr_calc (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .load    (a_adv),
    .a_cs    (a_cs),
    .a_rs    (a_rs),
    .a_rd    (a_rd),
    .a_cd    (a_cd),
    .a_flags (a_flags),
    .advance (b_adv),
    .b_valid (b_valid),
    .b_addr  (b_addr),
    .b_flags (b_flags)
  );

  nlra_cmd_seq u_cmd_seq (
    .clk       (clk),
    .rst       (rst),
    .load      (b_adv),
    .b_addr    (b_addr),
    .b_flags   (b_flags),
    .slot_free (slot_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for nv21_lut_remap_address_gen
// depends on nlra_pkg and the block's rtl; the copy command predictor lives in a small class
// directed remap entries first, then random config phases with random entries and backpressure

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nlra_pkg::*;

  localparam int MAX_DIM = 4096;
  localparam int RANDOM_ENTRIES = 330;
  localparam int DIRECTED_ENTRIES = 23;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [ADDR_W-1:0] read_addr;
    logic [ADDR_W-1:0] write_addr;
    logic              plane;
    logic              last_of_entry;
    logic              region_done;
  } copy_cmd_t;

  class copy_cmd_scoreboard;
    logic [SIZE_CFG_W-1:0] region_rows, region_cols, dst_width, src_width;
    logic [OFF_W-1:0]      offset_x, offset_y;
    int unsigned           row_cnt, col_cnt;
    copy_cmd_t             pending_cmds[$];
    int unsigned           mismatches;

    function new();
      region_rows = 1;
      region_cols = 1;
      offset_x    = 0;
      offset_y    = 0;
      dst_width   = 1280;
      src_width   = 1280;
      row_cnt     = 0;
      col_cnt     = 0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_REGION_ROWS: region_rows = data[SIZE_CFG_W-1:0];
        REG_REGION_COLS: region_cols = data[SIZE_CFG_W-1:0];
        REG_OFFSET_X:    offset_x    = data[OFF_W-1:0];
        REG_OFFSET_Y:    offset_y    = data[OFF_W-1:0];
        REG_DST_WIDTH:   dst_width   = data[SIZE_CFG_W-1:0];
        REG_SRC_WIDTH:   src_width   = data[SIZE_CFG_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_size(logic [SIZE_CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function void note_entry(logic [COORD_W-1:0] src_col, logic [COORD_W-1:0] src_row);
      int unsigned     rows, cols;
      longint unsigned dst_row, dst_col, luma_rd, luma_wr, chroma_rd, chroma_wr;
      bit              last_col, last_row, chroma;
      copy_cmd_t       cmd;
      rows      = eff_size(region_rows);
      cols      = eff_size(region_cols);
      dst_row   = longint'(row_cnt) + longint'(offset_y);
      dst_col   = longint'(col_cnt) + longint'(offset_x);
      last_col  = (col_cnt + 1 >= cols);
      last_row  = (row_cnt + 1 >= rows);
      chroma    = dst_row[0] & dst_col[0];
      luma_rd   = longint'(src_row) * longint'(src_width) + longint'(src_col);
      luma_wr   = dst_row * longint'(dst_width) + dst_col;
      chroma_rd = longint'(src_row >> 1) * longint'(src_width)
                  + longint'({src_col[COORD_W-1:1], 1'b0});
      chroma_wr = (dst_row >> 1) * longint'(dst_width) + dst_col;

      cmd.read_addr     = luma_rd[ADDR_W-1:0];
      cmd.write_addr    = luma_wr[ADDR_W-1:0];
      cmd.plane         = 1'b0;
      cmd.last_of_entry = !chroma;
      cmd.region_done   = !chroma && last_col && last_row;
      pending_cmds.push_back(cmd);
      if (chroma) begin
        cmd.read_addr     = chroma_rd[ADDR_W-1:0];
        cmd.write_addr    = ADDR_W'(chroma_wr - 1);
        cmd.plane         = 1'b1;
        cmd.last_of_entry = 1'b0;
        cmd.region_done   = 1'b0;
        pending_cmds.push_back(cmd);
        cmd.read_addr     = ADDR_W'(chroma_rd + 1);
        cmd.write_addr    = chroma_wr[ADDR_W-1:0];
        cmd.last_of_entry = 1'b1;
        cmd.region_done   = last_col && last_row;
        pending_cmds.push_back(cmd);
      end

      if (last_col) begin
        col_cnt = 0;
        row_cnt = last_row ? 0 : row_cnt + 1;
      end else begin
        col_cnt = col_cnt + 1;
      end
    endfunction

    function void check_cmd(copy_cmd_t got);
      copy_cmd_t want;
      if (pending_cmds.size() == 0) begin
        $error("unexpected copy command: read_addr %0h write_addr %0h",
               got.read_addr, got.write_addr);
        mismatches++;
        return;
      end
      want = pending_cmds.pop_front();
      if (got.read_addr !== want.read_addr) begin
        $error("read_addr: expected %0h, got %0h", want.read_addr, got.read_addr);
        mismatches++;
      end
      if (got.write_addr !== want.write_addr) begin
        $error("write_addr: expected %0h, got %0h", want.write_addr, got.write_addr);
        mismatches++;
      end
      if (got.plane !== want.plane) begin
        $error("plane: expected %0b, got %0b", want.plane, got.plane);
        mismatches++;
      end
      if (got.last_of_entry !== want.last_of_entry) begin
        $error("last_of_entry: expected %0b, got %0b", want.last_of_entry, got.last_of_entry);
        mismatches++;
      end
      if (got.region_done !== want.region_done) begin
        $error("region_done: expected %0b, got %0b", want.region_done, got.region_done);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [23:0]           s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [47:0]           m_tdata;
  logic [1:0]            m_tuser;
  logic                  m_tlast;

  copy_cmd_scoreboard cmd_board = new();
  int unsigned        entries_in = 0;
  int unsigned        burst_left = 0;

  nv21_lut_remap_address_gen #(.MAX_DIM(MAX_DIM)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      cmd_board.check_cmd(copy_cmd_t'{read_addr: m_tdata[23:0], write_addr: m_tdata[47:24],
                                      plane: m_tuser[0], last_of_entry: m_tuser[1],
                                      region_done: m_tlast});
  end

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cmd_board.write_reg(idx, data);
  endtask

  task automatic send_entry(logic [COORD_W-1:0] src_col, logic [COORD_W-1:0] src_row);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {src_row, src_col};
    do @(posedge clk); while (!s_tready);
    cmd_board.note_entry(src_col, src_row);
    entries_in++;
    burst_left--;
  endtask

  task automatic end_phase();
    s_tvalid <= 1'b0;
    while (cmd_board.pending_cmds.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return CFG_DATA_W'(MAX_DIM);
      2:       return 13'd8191;
      3:       return CFG_DATA_W'(MAX_DIM + 1);
      default: return CFG_DATA_W'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_offset();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 13'd4095;
      default: return CFG_DATA_W'($urandom_range(0, 8191));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_stride();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 13'd8191;
      2:       return 13'd1;
      3:       return CFG_DATA_W'($urandom_range(0, 8191));
      default: return CFG_DATA_W'($urandom_range(2, 4096));
    endcase
  endfunction

  task automatic random_config();
    if ($urandom_range(0, 3) == 0)
      cfg_write(($urandom_range(0, 1) == 1) ? REG_UNUSED_HI : REG_UNUSED_LO,
                CFG_DATA_W'($urandom_range(0, 8191)));
    cfg_write(REG_REGION_ROWS, pick_size());
    cfg_write(REG_REGION_COLS, pick_size());
    cfg_write(REG_OFFSET_X, pick_offset());
    cfg_write(REG_OFFSET_Y, pick_offset());
    cfg_write(REG_DST_WIDTH, pick_stride());
    cfg_write(REG_SRC_WIDTH, pick_stride());
    cfg_valid <= 1'b0;
  endtask

  initial begin : receiver
    int unsigned mode, span, pat_i;
    logic [31:0] ready_pat;
    bit          long_hold_done;
    long_hold_done = 0;
    pat_i = 0;
    forever begin
      mode      = $urandom_range(0, 3);
      span      = $urandom_range(20, 120);
      ready_pat = $urandom;
      repeat (span) begin
        @(posedge clk);
        if (!long_hold_done && entries_in >= 150 && s_tvalid) begin
          long_hold_done = 1;
          m_tready <= 1'b0;
          repeat (300) @(posedge clk);
        end
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 1) == 1);
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ready_pat[pat_i % 32];
        endcase
        pat_i++;
      end
    end
  end

  initial begin : stimulus
    int unsigned n_entries;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset config: 1x1 region, every entry ends the region, luma only
    send_entry(12'd0, 12'd0);
    send_entry(12'd4095, 12'd4095);
    send_entry(12'hAAA, 12'h555);
    send_entry(12'h555, 12'hAAA);
    end_phase();

    // odd offsets put chroma on the first entry, max strides overflow the address
    cfg_write(REG_REGION_ROWS, 13'd2);
    cfg_write(REG_REGION_COLS, 13'd2);
    cfg_write(REG_OFFSET_X, 13'd1);
    cfg_write(REG_OFFSET_Y, 13'd1);
    cfg_write(REG_DST_WIDTH, 13'd8191);
    cfg_write(REG_SRC_WIDTH, 13'd8191);
    cfg_valid <= 1'b0;
    send_entry(12'd4095, 12'd4095);
    send_entry(12'd1, 12'd3);
    send_entry(12'd4094, 12'd1);
    send_entry(12'd0, 12'd4095);
    end_phase();

    // region end lands on a chroma entry, zero and unit strides
    cfg_write(REG_OFFSET_X, 13'd0);
    cfg_write(REG_OFFSET_Y, 13'd0);
    cfg_write(REG_DST_WIDTH, 13'd0);
    cfg_write(REG_SRC_WIDTH, 13'd1);
    cfg_valid <= 1'b0;
    send_entry(12'd7, 12'd9);
    send_entry(12'd4095, 12'd0);
    send_entry(12'd0, 12'd4095);
    send_entry(12'd3, 12'd3);
    end_phase();

    // stop mid-region, then shrink the region under the counters
    cfg_write(REG_REGION_ROWS, 13'd4);
    cfg_write(REG_REGION_COLS, 13'd4);
    cfg_write(REG_OFFSET_X, 13'd4095);
    cfg_write(REG_OFFSET_Y, 13'd4095);
    cfg_write(REG_DST_WIDTH, 13'd2);
    cfg_write(REG_SRC_WIDTH, 13'd4096);
    cfg_valid <= 1'b0;
    repeat (6) send_entry(COORD_W'($urandom_range(0, 4095)), COORD_W'($urandom_range(0, 4095)));
    end_phase();
    cfg_write(REG_REGION_COLS, 13'd2);
    cfg_write(REG_REGION_ROWS, 13'd1);
    cfg_write(REG_UNUSED_LO, 13'd8191);
    cfg_write(REG_UNUSED_HI, 13'd8191);
    cfg_valid <= 1'b0;
    send_entry(12'd100, 12'd200);
    send_entry(12'd4095, 12'd1);
    end_phase();

    // sizes past the limit and zero act as clamped
    cfg_write(REG_REGION_ROWS, 13'd8191);
    cfg_write(REG_REGION_COLS, 13'd0);
    cfg_valid <= 1'b0;
    repeat (3) send_entry(COORD_W'($urandom_range(0, 4095)), COORD_W'($urandom_range(0, 4095)));
    end_phase();

    while (entries_in < DIRECTED_ENTRIES + RANDOM_ENTRIES) begin
      random_config();
      n_entries = $urandom_range(8, 40);
      repeat (n_entries)
        send_entry(COORD_W'($urandom_range(0, 4095)), COORD_W'($urandom_range(0, 4095)));
      end_phase();
    end

    repeat (10) @(posedge clk);
    if (cmd_board.mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/nlra_pkg.sv
sv/nlra_position.sv
sv/nlra_addr_calc.sv
sv/nlra_cmd_seq.sv
sv/nv21_lut_remap_address_gen.sv
dv/tb_top.sv
